// ----- hdl/plen_pkg.sv -----
// shared types and constants for the polyline length accumulator
// no dependencies; used by plen_sqrt, plen_store and the top level
package plen_pkg;

    // field widths
    localparam int COORD_W   = 16;
    localparam int INDEX_W   = 8;
    localparam int COUNT_O_W = 9;
    localparam int LEN_W     = 32;

    // square root datapath
    localparam int SQ_W   = 2 * COORD_W;     // one square, 16x16
    localparam int RAD_W  = SQ_W + 2;        // sum of squares, padded to even width
    localparam int ROOT_W = RAD_W / 2;       // root bits, one per step
    localparam int REM_W  = ROOT_W + 3;      // partial remainder
    localparam int STEP_W = $clog2(ROOT_W);

    // stream payload widths
    localparam int IN_DATA_W  = 40;          // x, y, index
    localparam int OUT_BITS   = COUNT_O_W + LEN_W + 2 * COORD_W + 1;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // item kinds
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_point;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_SQRT,
        S_WAIT,
        S_COMMIT,
        S_READ,
        S_OUT
    } t_state;

endpackage

// ----- hdl/plen_sqrt.sv -----
// bit-serial floor square root, one result bit per cycle
// depends on plen_pkg
module plen_sqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [plen_pkg::RAD_W-1:0]   i_radicand,
    output logic                         o_done,
    output logic [plen_pkg::ROOT_W-1:0]  o_root
);

    logic                          r_busy;
    logic                          r_done;
    logic [plen_pkg::RAD_W-1:0]    r_rad;
    logic [plen_pkg::REM_W-1:0]    r_rem;
    logic [plen_pkg::ROOT_W-1:0]   r_root;
    logic [plen_pkg::STEP_W-1:0]   r_step;

    logic [plen_pkg::REM_W-1:0]    w_rem_sh;
    logic [plen_pkg::REM_W-1:0]    w_trial;
    logic                          w_fit;

    // bring in the next two radicand bits and try the next root bit
    assign w_rem_sh = {r_rem[plen_pkg::REM_W-3:0], r_rad[plen_pkg::RAD_W-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + plen_pkg::STEP_W'(1);
                if (r_step == plen_pkg::STEP_W'(plen_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // digit shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[plen_pkg::RAD_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[plen_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[plen_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- hdl/plen_store.sv -----
// point memory, one write and one registered read per cycle
// depends on plen_pkg
module plen_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  plen_pkg::t_point     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output plen_pkg::t_point     o_rd_data
);

    plen_pkg::t_point r_mem [DEPTH];
    plen_pkg::t_point r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/polyline_length_accumulator_top.sv -----
// polyline length accumulator: an add item steps through the difference, square,
// square root (bit-serial), wait and commit states, the first add straight to commit, a
// read item through the read state, a refused add straight to output; one item in flight,
// next accepted the cycle after the result is loaded; output register holds it
// reset (synchronous, active low) empties the list, zeroes the length, no ready
// depends on plen_pkg, plen_sqrt, plen_store
module polyline_length_accumulator_top #(
    parameter int MAX_POINTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: x_coord[15:0], y_coord[31:16], point_index[39:32]
    input  logic [plen_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: action[0]
    input  logic                              i_s_axis_tuser,
    // master side
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: point_count[8:0], path_length[40:9], x_out[56:41], y_out[72:57],
    //        error_flag[73], zero[79:74]
    output logic [plen_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int CMPW = (CW > plen_pkg::INDEX_W) ? CW : plen_pkg::INDEX_W;
    localparam int PADW = plen_pkg::OUT_DATA_W - plen_pkg::OUT_BITS;

    plen_pkg::t_state r_state, n_state;

    logic [plen_pkg::COORD_W-1:0]  r_x, r_y;
    logic [plen_pkg::INDEX_W-1:0]  r_idx;
    logic [plen_pkg::COORD_W-1:0]  r_last_x, r_last_y;
    logic [plen_pkg::COORD_W-1:0]  r_ax, r_ay;
    logic [plen_pkg::SQ_W-1:0]     r_sqx, r_sqy;
    logic [plen_pkg::ROOT_W-1:0]   r_seg;
    logic [CW-1:0]                 r_count;
    logic [plen_pkg::LEN_W-1:0]    r_length;
    logic [plen_pkg::COORD_W-1:0]  r_xo, r_yo;
    logic                          r_err;
    logic                          r_out_valid;
    logic [plen_pkg::OUT_DATA_W-1:0] r_out_data;

    logic                          w_in_acc;
    logic                          w_in_act;
    logic [plen_pkg::COORD_W-1:0]  w_in_x, w_in_y;
    logic [plen_pkg::INDEX_W-1:0]  w_in_idx;
    logic                          w_full;
    logic                          w_out_free;
    logic                          w_load;
    logic                          w_sqrt_start;
    logic                          w_rd_en;
    logic                          w_wr_en;
    logic                          w_hit;
    logic signed [plen_pkg::COORD_W:0] w_dx, w_dy;
    logic [plen_pkg::LEN_W:0]      w_len_sum;
    logic [plen_pkg::RAD_W-1:0]    w_radicand;
    logic                          w_sqrt_done;
    logic [plen_pkg::ROOT_W-1:0]   w_root;
    plen_pkg::t_point              w_wr_data;
    plen_pkg::t_point              w_rd_data;

    // input fields
    assign w_in_act = i_s_axis_tuser;
    assign w_in_x   = i_s_axis_tdata[15:0];
    assign w_in_y   = i_s_axis_tdata[31:16];
    assign w_in_idx = i_s_axis_tdata[39:32];

    assign o_s_axis_tready = i_rst_n && (r_state == plen_pkg::S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count == CW'(MAX_POINTS));
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    // next state and strobes
    always_comb begin
        n_state      = r_state;
        w_sqrt_start = 1'b0;
        w_rd_en      = 1'b0;
        w_wr_en      = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            plen_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (w_in_act == plen_pkg::ACT_READ) begin
                        w_rd_en = 1'b1;
                        n_state = plen_pkg::S_READ;
                    end else if (w_full) begin
                        n_state = plen_pkg::S_OUT;
                    end else if (r_count == '0) begin
                        n_state = plen_pkg::S_COMMIT;
                    end else begin
                        n_state = plen_pkg::S_DIFF;
                    end
                end
            end
            plen_pkg::S_DIFF:   n_state = plen_pkg::S_MUL;
            plen_pkg::S_MUL:    n_state = plen_pkg::S_SQRT;
            plen_pkg::S_SQRT: begin
                w_sqrt_start = 1'b1;
                n_state      = plen_pkg::S_WAIT;
            end
            plen_pkg::S_WAIT: begin
                if (w_sqrt_done) begin
                    n_state = plen_pkg::S_COMMIT;
                end
            end
            plen_pkg::S_COMMIT: begin
                w_wr_en = 1'b1;
                n_state = plen_pkg::S_OUT;
            end
            plen_pkg::S_READ:   n_state = plen_pkg::S_OUT;
            plen_pkg::S_OUT: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = plen_pkg::S_IDLE;
                end
            end
            default:            n_state = plen_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plen_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // differences, squares and radicand
    assign w_dx       = $signed({r_x[plen_pkg::COORD_W-1], r_x})
                      - $signed({r_last_x[plen_pkg::COORD_W-1], r_last_x});
    assign w_dy       = $signed({r_y[plen_pkg::COORD_W-1], r_y})
                      - $signed({r_last_y[plen_pkg::COORD_W-1], r_last_y});
    assign w_radicand = plen_pkg::RAD_W'({1'b0, r_sqx} + {1'b0, r_sqy});

    // saturating length update
    assign w_len_sum  = {1'b0, r_length} + (plen_pkg::LEN_W + 1)'(r_seg);

    // read hit: index below the point count
    assign w_hit = (CMPW'(r_idx) < CMPW'(r_count));

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x   <= w_in_x;
            r_y   <= w_in_y;
            r_idx <= w_in_idx;
            r_xo  <= '0;
            r_yo  <= '0;
            r_err <= (w_in_act == plen_pkg::ACT_ADD) && w_full;
            r_seg <= '0;
        end
        if (r_state == plen_pkg::S_DIFF) begin
            r_ax <= w_dx[plen_pkg::COORD_W] ? plen_pkg::COORD_W'(-w_dx)
                                            : plen_pkg::COORD_W'(w_dx);
            r_ay <= w_dy[plen_pkg::COORD_W] ? plen_pkg::COORD_W'(-w_dy)
                                            : plen_pkg::COORD_W'(w_dy);
        end
        if (r_state == plen_pkg::S_MUL) begin
            r_sqx <= plen_pkg::SQ_W'(r_ax) * plen_pkg::SQ_W'(r_ax);
            r_sqy <= plen_pkg::SQ_W'(r_ay) * plen_pkg::SQ_W'(r_ay);
        end
        if ((r_state == plen_pkg::S_WAIT) && w_sqrt_done) begin
            r_seg <= w_root;
        end
        if (r_state == plen_pkg::S_READ && w_hit) begin
            r_xo <= w_rd_data.x;
            r_yo <= w_rd_data.y;
        end
    end

    // list state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_length <= '0;
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (w_wr_en) begin
            r_count  <= r_count + CW'(1);
            r_last_x <= r_x;
            r_last_y <= r_y;
            r_length <= w_len_sum[plen_pkg::LEN_W] ? '1 : w_len_sum[plen_pkg::LEN_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {PADW'(0), r_err, r_yo, r_xo, r_length,
                           plen_pkg::COUNT_O_W'(r_count)};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // point store
    assign w_wr_data.x = r_x;
    assign w_wr_data.y = r_y;

    plen_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(r_count)),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (AW'(w_in_idx)),
        .o_rd_data (w_rd_data)
    );

    // segment length
    plen_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_radicand),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

endmodule
